[design/hpdd_pkg.sv]
`default_nettype none

package hpdd_pkg;

   // pipeline depth, entry stage to result register
   localparam int NUM_ST = 8;

   // configuration register indexes
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_SEED    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_PERCENT = 8'd1;

   // field widths
   localparam int SEED_W = 32;
   localparam int PCT_W  = 8;
   localparam int SEQ_W  = 32;
   localparam int KIND_W = 8;
   localparam int HASH_W = 32;
   localparam int REM_W  = 7;

   localparam logic [PCT_W-1:0] PCT_NONE = 8'd0;
   localparam logic [PCT_W-1:0] PCT_FULL = 8'd100;

   // hash constants
   localparam logic [31:0] KIND_MUL = 32'h9E37_79B9;
   localparam logic [63:0] GAMMA    = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX1     = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX2     = 64'h94D0_49BB_1331_11EB;

   // x / 100 == (x * RECIP_100) >> 37 for every 32-bit x
   localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
   localparam logic [31:0] MOD_BASE  = 32'd100;

   // per-beat decision carried down the pipe
   typedef enum logic [1:0] {
      DEC_KEEP = 2'b00,
      DEC_DROP = 2'b01,
      DEC_HASH = 2'b10
   } dec_type;

endpackage

`default_nettype wire

[design/hashed_packet_drop_decider.sv]
// Hashed packet drop decider: per-packet keep/drop for loss injection.
//
// Request channel (req_valid/req_stall) carries seq_number, packet_kind and
// is_resend; response channel (rsp_valid/rsp_stall) returns one drop bit per
// request beat, in order. A beat moves when valid is high and stall is low.
// CSR channel (csr_valid/csr_ready, csr_ready always high): index 0 is the
// 32-bit loss seed, index 1 the 8-bit loss percent; other indexes are ignored.
// Write the CSRs only while no beat is in flight.
//
// Eight register stages; one request beat per cycle is accepted while
// req_stall is low. The depth comes from the kind mix and gamma add, the two
// 64-bit finalizer multiplies, each split into 32x32 partial products with a
// summing stage after, plus the reciprocal multiply and remainder for the
// modulo 100.
// Reset clears the pipeline valid bits and both CSRs (injection off).
// When rsp_stall is high a valid result register holds; earlier stages keep
// filling until the pipe is full, then req_stall rises.

`default_nettype none

module hashed_packet_drop_decider #(
   parameter logic [31:0] SEED_OFF = 32'd0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [hpdd_pkg::SEQ_W-1:0]       req_seq_number,
   input  wire logic [hpdd_pkg::KIND_W-1:0]      req_packet_kind,
   input  wire logic                             req_is_resend,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic                             rsp_drop,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [hpdd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                      csr_data
);

   localparam int LAST = hpdd_pkg::NUM_ST - 1;

   // configuration registers
   logic [hpdd_pkg::SEED_W-1:0] seed_ff;
   logic [hpdd_pkg::PCT_W-1:0]  pct_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         pct_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hpdd_pkg::CSR_LOSS_SEED:    seed_ff <= csr_data;
            hpdd_pkg::CSR_LOSS_PERCENT: pct_ff  <= csr_data[hpdd_pkg::PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valids and per-stage load enables (bubbles collapse)
   logic [LAST:0] v_ff;
   logic [LAST:0] v_in;
   logic [LAST:0] en;

   always_comb begin
      en[LAST] = !v_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int k = 1; k <= LAST; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[LAST];

   // decision code, travels with each beat
   hpdd_pkg::dec_type dec_ff [LAST];
   hpdd_pkg::dec_type dec0_in;
   logic              inj_on;

   always_comb begin
      inj_on = (seed_ff != SEED_OFF) && (pct_ff != hpdd_pkg::PCT_NONE) &&
               (pct_ff <= hpdd_pkg::PCT_FULL);
      if (!inj_on || req_is_resend) begin
         dec0_in = hpdd_pkg::DEC_KEEP;
      end else if (pct_ff == hpdd_pkg::PCT_FULL) begin
         dec0_in = hpdd_pkg::DEC_DROP;
      end else begin
         dec0_in = hpdd_pkg::DEC_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dec_ff[0] <= dec0_in;
      end
      for (int k = 1; k < LAST; k++) begin
         if (en[k]) begin
            dec_ff[k] <= dec_ff[k-1];
         end
      end
   end

   // stage 0: mix packet kind into the sequence number
   logic [31:0] s0_ff, s0_in;
   assign s0_in = req_seq_number ^ (32'(req_packet_kind) * hpdd_pkg::KIND_MUL);

   // stage 1: seed in high half, add gamma, first xor-shift
   logic [63:0] x1_ff, x1_in, m1_add;
   always_comb begin
      m1_add = {seed_ff, s0_ff} + hpdd_pkg::GAMMA;
      x1_in  = m1_add ^ (m1_add >> 30);
   end

   // stage 2: partial products of x1 * MIX1
   logic [63:0] pa_ll_ff, pa_ll_in;
   logic [31:0] pa_lh_ff, pa_lh_in, pa_hl_ff, pa_hl_in;
   always_comb begin
      pa_ll_in = 64'(x1_ff[31:0]) * 64'(hpdd_pkg::MIX1[31:0]);
      pa_lh_in = x1_ff[31:0]  * hpdd_pkg::MIX1[63:32];
      pa_hl_in = x1_ff[63:32] * hpdd_pkg::MIX1[31:0];
   end

   // stage 3: sum partials, second xor-shift
   logic [63:0] x2_ff, x2_in, m2_sum;
   always_comb begin
      m2_sum = pa_ll_ff + {pa_lh_ff + pa_hl_ff, 32'd0};
      x2_in  = m2_sum ^ (m2_sum >> 27);
   end

   // stage 4: partial products of x2 * MIX2
   logic [63:0] pb_ll_ff, pb_ll_in;
   logic [31:0] pb_lh_ff, pb_lh_in, pb_hl_ff, pb_hl_in;
   always_comb begin
      pb_ll_in = 64'(x2_ff[31:0]) * 64'(hpdd_pkg::MIX2[31:0]);
      pb_lh_in = x2_ff[31:0]  * hpdd_pkg::MIX2[63:32];
      pb_hl_in = x2_ff[63:32] * hpdd_pkg::MIX2[31:0];
   end

   // stage 5: sum partials, final xor-shift, fold to 32 bits
   logic [hpdd_pkg::HASH_W-1:0] h5_ff, h5_in;
   logic [63:0] m3_sum, m3_mix;
   always_comb begin
      m3_sum = pb_ll_ff + {pb_lh_ff + pb_hl_ff, 32'd0};
      m3_mix = m3_sum ^ (m3_sum >> 31);
      h5_in  = m3_mix[31:0] ^ m3_mix[63:32];
   end

   // stage 6: reciprocal multiply for the quotient by 100
   logic [63:0] qp_ff, qp_in;
   logic [hpdd_pkg::HASH_W-1:0] h6_ff;
   assign qp_in = 64'(h5_ff) * 64'(hpdd_pkg::RECIP_100);

   // stage 7: remainder, compare, result register
   logic [25:0] quot;
   logic [31:0] rem_full;
   logic [hpdd_pkg::REM_W-1:0] rem;
   logic drop_ff, drop_in;
   always_comb begin
      quot     = qp_ff[62:37];
      rem_full = h6_ff - (32'(quot) * hpdd_pkg::MOD_BASE);
      rem      = rem_full[hpdd_pkg::REM_W-1:0];
      case (dec_ff[LAST-1])
         hpdd_pkg::DEC_DROP: drop_in = 1'b1;
         hpdd_pkg::DEC_HASH: drop_in = (8'(rem) < pct_ff);
         default:            drop_in = 1'b0;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en[0]) s0_ff <= s0_in;
      if (en[1]) x1_ff <= x1_in;
      if (en[2]) begin
         pa_ll_ff <= pa_ll_in;
         pa_lh_ff <= pa_lh_in;
         pa_hl_ff <= pa_hl_in;
      end
      if (en[3]) x2_ff <= x2_in;
      if (en[4]) begin
         pb_ll_ff <= pb_ll_in;
         pb_lh_ff <= pb_lh_in;
         pb_hl_ff <= pb_hl_in;
      end
      if (en[5]) h5_ff <= h5_in;
      if (en[6]) begin
         qp_ff <= qp_in;
         h6_ff <= h5_ff;
      end
      if (en[7]) drop_ff <= drop_in;
   end

   assign rsp_drop = drop_ff;

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v_ff[0] && rsp_stall))
      else $error("request stalled while entry stage could move");

   a_keep_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (en[LAST] && v_ff[LAST-1] && (dec_ff[LAST-1] == hpdd_pkg::DEC_KEEP)) |=> !rsp_drop)
      else $error("kept beat produced a drop");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAST-1] && (dec_ff[LAST-1] == hpdd_pkg::DEC_HASH)) |-> (rem_full < 32'd100))
      else $error("modulo-100 remainder out of range");

   a_full_drops: assert property (@(posedge clock) disable iff (reset)
      (en[LAST] && v_ff[LAST-1] && (dec_ff[LAST-1] == hpdd_pkg::DEC_DROP)) |=> rsp_drop)
      else $error("full-loss beat was kept");

endmodule

`default_nettype wire

[bench/hpdd_tb_pkg.sv]
package hpdd_tb_pkg;

   import hpdd_pkg::*;

   // disabled-seed sentinel, matches the block's default parameter
   localparam logic [31:0] SEED_OFF = 32'd0;

   // register indexes the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 8'hFF;

   // splitmix64 constants, written out independently of the design package
   localparam logic [31:0] GOLDEN_32  = 32'h9E37_79B9;
   localparam logic [63:0] GOLDEN_64  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] FINAL_MUL1 = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] FINAL_MUL2 = 64'h94D0_49BB_1331_11EB;
   localparam logic [31:0] PCT_SCALE  = 32'd100;

   // Tracks the configuration, predicts a drop bit per accepted packet and
   // checks returned beats in order.
   class drop_tracker;
      logic [SEED_W-1:0] loss_seed;
      logic [PCT_W-1:0]  loss_pct;
      bit                pending_drops[$];
      int                errors;

      function new();
         loss_seed = '0;
         loss_pct  = '0;
         errors    = 0;
      endfunction

      // mirror a register write; unknown indexes leave both alone
      function void note_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         if (idx == CSR_LOSS_SEED)
            loss_seed = val;
         else if (idx == CSR_LOSS_PERCENT)
            loss_pct = val[PCT_W-1:0];
      endfunction

      // kind folded into seq, seed on top, splitmix64 finalise, fold to 32
      function logic [31:0] packet_hash(logic [31:0] seq, logic [7:0] kind);
         logic [31:0] kind_mix;
         logic [63:0] m;
         kind_mix = {24'd0, kind} * GOLDEN_32;
         m = {loss_seed, seq ^ kind_mix} + GOLDEN_64;
         m = (m ^ (m >> 30)) * FINAL_MUL1;
         m = (m ^ (m >> 27)) * FINAL_MUL2;
         m = m ^ (m >> 31);
         return m[31:0] ^ m[63:32];
      endfunction

      function bit predict_drop(logic [31:0] seq, logic [7:0] kind, logic resend);
         bit enabled;
         enabled = (loss_seed != SEED_OFF) && (loss_pct != 8'd0) && (loss_pct <= 8'd100);
         // retransmits bypass the hash entirely
         if (!enabled || resend)
            return 1'b0;
         if (loss_pct >= 8'd100)
            return 1'b1;
         return (packet_hash(seq, kind) % PCT_SCALE) < {24'd0, loss_pct};
      endfunction

      function void note_packet(logic [31:0] seq, logic [7:0] kind, logic resend);
         pending_drops.push_back(predict_drop(seq, kind, resend));
      endfunction

      function void check_drop(logic actual);
         bit exp_drop;
         if (pending_drops.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got drop=%0b",
                     $time, actual);
            errors++;
            return;
         end
         exp_drop = pending_drops.pop_front();
         if (actual !== exp_drop) begin
            $display("%0t: drop mismatch, expected %0b, got %0b", $time, exp_drop, actual);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_drops.size();
      endfunction

      function void check_drained();
         if (pending_drops.size() != 0) begin
            $display("%0t: results missing, expected %0d more beats, got 0",
                     $time, pending_drops.size());
            errors++;
         end
      endfunction
   endclass

endpackage

[bench/tb_top.sv]
module tb_top;

   import hpdd_pkg::*;
   import hpdd_tb_pkg::*;

   localparam int LATENCY       = NUM_ST;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SEGMENTS      = 7;
   localparam int SEGMENT_ITEMS = 48;
   localparam int LONG_HOLD     = 120;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SEQ_W-1:0]     req_seq_number;
   logic [KIND_W-1:0]    req_packet_kind;
   logic                 req_is_resend;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_drop;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;

   int tx_idle_pct;
   int rx_stall_pct;
   int hold_cycles;

   drop_tracker sb;

   hashed_packet_drop_decider #(
      .SEED_OFF(SEED_OFF)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seq_number (req_seq_number),
      .req_packet_kind(req_packet_kind),
      .req_is_resend  (req_is_resend),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drop       (rsp_drop),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // result side: check accepted beats, then pick next cycle's stall
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_drop(rsp_drop);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   // offer one packet, with random idle cycles ahead of it; valid stays high
   task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [KIND_W-1:0] kind,
                              input logic resend);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_seq_number  <= seq;
      req_packet_kind <= kind;
      req_is_resend   <= resend;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_packet(seq, kind, resend);
   endtask

   // one register beat; csr_valid is left high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.note_write(idx, val);
   endtask

   task automatic configure(input logic [31:0] seed, input logic [31:0] pct_word);
      write_reg(CSR_LOSS_SEED, seed);
      write_reg(CSR_LOSS_PERCENT, pct_word);
      csr_valid <= 1'b0;
   endtask

   // stop offering, wait for every result, then let the pipe run empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      logic [31:0] seed;
      logic [31:0] pct_word;
      logic [31:0] seq;

      sb           = new();
      tx_idle_pct  = 26;
      rx_stall_pct = 64;
      hold_cycles  = 0;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_seq_number  <= '0;
      req_packet_kind <= '0;
      req_is_resend   <= 1'b0;
      rsp_stall       <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= '0;
      csr_data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // injection off out of reset
      send_packet(32'h0000_0000, 8'h00, 1'b0);
      send_packet(32'hFFFF_FFFF, 8'hFF, 1'b0);
      settle();

      // writes to unused indexes must not enable anything
      write_reg(CSR_UNUSED_LO, 32'hFFFF_FFFF);
      write_reg(CSR_UNUSED_HI, 32'h0000_0064);
      csr_valid <= 1'b0;
      send_packet(32'h1234_5678, 8'h5A, 1'b0);
      settle();

      // full loss, retransmit still kept
      configure(32'hFFFF_FFFF, 32'd100);
      send_packet(32'h0000_0000, 8'h00, 1'b0);
      send_packet(32'hFFFF_FFFF, 8'hFF, 1'b0);
      send_packet(32'h8000_0001, 8'h80, 1'b1);
      send_packet(32'h7FFF_FFFE, 8'h7F, 1'b0);
      settle();

      // percent word with junk above bit 7 gives 50
      configure(32'h0000_0001, 32'hFFFF_FF32);
      send_packet(32'h0000_0000, 8'h00, 1'b0);
      send_packet(32'hFFFF_FFFF, 8'hFF, 1'b0);
      send_packet(32'h0000_0001, 8'h01, 1'b0);
      send_packet(32'h8000_0000, 8'h80, 1'b0);
      send_packet(32'hAAAA_5555, 8'h55, 1'b1);
      send_packet(32'h5555_AAAA, 8'hAA, 1'b0);
      settle();

      // percent out of range or zero: off
      configure(32'hA5A5_5A5A, 32'd101);
      send_packet(32'h0000_0010, 8'h03, 1'b0);
      settle();
      configure(32'hA5A5_5A5A, 32'd255);
      send_packet(32'h0000_0011, 8'h04, 1'b0);
      settle();
      configure(32'hA5A5_5A5A, 32'd0);
      send_packet(32'h0000_0012, 8'h05, 1'b0);
      settle();

      // seed at the sentinel: off
      configure(SEED_OFF, 32'd50);
      send_packet(32'hFFFF_FFFF, 8'hFF, 1'b0);
      send_packet(32'h0000_0000, 8'h00, 1'b0);
      settle();

      // lowest and highest hashed percent
      configure(32'hDEAD_BEEF, 32'd1);
      send_packet(32'h0000_0000, 8'h00, 1'b0);
      send_packet(32'hFFFF_FFFF, 8'hFF, 1'b0);
      send_packet(32'h0000_0063, 8'h11, 1'b0);
      settle();
      configure(32'hDEAD_BEEF, 32'd99);
      send_packet(32'h0000_0000, 8'h00, 1'b0);
      send_packet(32'hFFFF_FFFF, 8'hFF, 1'b0);
      send_packet(32'h0000_0063, 8'h11, 1'b0);
      settle();

      // random traffic under three idle regimes
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               tx_idle_pct  = 26;
               rx_stall_pct = 64;
            end
            1: begin
               tx_idle_pct  = 64;
               rx_stall_pct = 26;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            seed = $urandom;
            case ($urandom_range(9))
               0: pct_word = 32'd100;
               1: pct_word = 32'($urandom_range(255, 101));
               2: pct_word = 32'd0;
               3: begin
                  seed     = SEED_OFF;
                  pct_word = 32'($urandom_range(99, 1));
               end
               4: pct_word = {24'($urandom), 8'($urandom_range(99, 1))};
               default: pct_word = 32'($urandom_range(99, 1));
            endcase
            if ($urandom_range(3) == 0)
               write_reg(8'($urandom_range(255, 2)), $urandom);
            configure(seed, pct_word);

            // back-pressure burst: receiver holds while the sender keeps going
            if (mode == 2 && seg == 0)
               hold_cycles = LONG_HOLD;

            repeat (SEGMENT_ITEMS) begin
               case ($urandom_range(15))
                  0: seq = 32'h0000_0000;
                  1: seq = 32'hFFFF_FFFF;
                  default: seq = $urandom;
               endcase
               send_packet(seq, 8'($urandom_range(255)), 1'($urandom_range(3) == 0));
            end
            settle();
         end
      end

      sb.check_drained();
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
